FILE: rtl/dpvae_pkg.sv
// Shared types and constants for the dual potentiometer valve angle estimator.
package dpvae_pkg;

  // Default sample width of both potentiometer channels.
  localparam int SAMPLE_BITS_DEF = 12;

  // Calibration register reset values.
  localparam int ZERO_RESET        = 423;
  localparam int LOW_NINETY_RESET  = 1998;
  localparam int HIGH_NINETY_RESET = 423;
  localparam int FULL_RESET        = 1998;

  // Calibration register indexes.
  localparam logic [1:0] REG_ZERO        = 2'd0;
  localparam logic [1:0] REG_LOW_NINETY  = 2'd1;
  localparam logic [1:0] REG_HIGH_NINETY = 2'd2;
  localparam logic [1:0] REG_FULL        = 2'd3;

  // Arithmetic constants.
  localparam int CAL_SCALE      = 1000;   // increment scale
  localparam int DEG_SPAN       = 90;     // degrees covered by one range
  localparam int TENTHS_SCALE   = 10000;  // scale of the tenths numerator
  localparam int TENTHS_CAP     = 900;    // tenths at which the cap applies
  localparam int LOW_CAP_DEG    = 89;
  localparam int HIGH_CAP_DEG   = 90;
  localparam int HIGH_BASE      = 90;
  localparam int FULL_SCALE_DEG = 180;
  localparam int ROUND_HALF     = 5;
  localparam int RECIP_TEN      = 205;    // x/10 == (x*205)>>11 for x below 1029
  localparam int RECIP_SHIFT    = 11;

  // Window limits.
  localparam int WIN_MARGIN     = 100;
  localparam int LOW_HIGH_ABOVE = 1500;
  localparam int LOW_HIGH_BELOW = 1300;
  localparam int HIGH_LOW_GUARD = 1200;

  // Range selection reported with each result.
  typedef enum logic [1:0] {
    RANGE_HELD = 2'd0,
    RANGE_LOW  = 2'd1,
    RANGE_HIGH = 2'd2
  } range_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SELECT,
    ST_SCALE,
    ST_INC,
    ST_TEN_GO,
    ST_TEN_WAIT,
    ST_ROUND,
    ST_EMIT
  } state_e;

  // Status of the divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: rtl/dpvae_div.sv
// Restoring divider, one quotient bit per cycle.
module dpvae_div #(
  parameter int NW = 26,
  parameter int DW = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NW-1:0]        num_i,
  input  logic [DW-1:0]        den_i,
  output logic [NW-1:0]        quot_o,
  output dpvae_pkg::div_stat_t stat_o
);

  localparam int CNTW = $clog2(NW + 1);

  logic [DW-1:0]   rem_q, rem_d;
  logic [NW-1:0]   acc_q, acc_d;
  logic [DW-1:0]   den_q, den_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DW:0]     trial;
  logic [DW:0]     sub;
  logic            ge;

  // One trial subtraction of the divisor from the shifted remainder.
  assign trial = {rem_q, acc_q[NW-1]};
  assign sub   = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_comb begin
    rem_d  = rem_q;
    acc_d  = acc_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      acc_d  = num_i;
      den_d  = den_i;
      cnt_d  = CNTW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? sub[DW-1:0] : trial[DW-1:0];
      acc_d = {acc_q[NW-2:0], ge};
      cnt_d = cnt_q - CNTW'(1);
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    acc_q <= acc_d;
    den_q <= den_d;
  end

  assign quot_o      = acc_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

FILE: rtl/dual_pot_valve_angle_estimator_top.sv
// Top level of the dual potentiometer valve angle estimator with its sequencer.
//
// Channel   Direction  Handshake                 Contents
// s_axis    in         tvalid/tready             tdata: sample_low, sample_high
// m_axis    out        tvalid/tready             tdata: angle_deg, report_angle; tuser: range
// cfg       in         cfg_we_i, no back-pressure cfg_addr_i, cfg_wdata_i
//
// An item that needs the division waits on the bit-serial divider for its result. An item
// with no window goes from the range selection straight to rounding, and one with a sample
// or an end point at or below the range start skips the increment and the division.
// Reset clears the calibration registers to their defaults and the held angle to zero.
// One item is in work at a time; a new request is taken once the result is loaded into
// the output register, which holds it while the output side stalls.
module dual_pot_valve_angle_estimator_top #(
  parameter int SAMPLE_BITS = dpvae_pkg::SAMPLE_BITS_DEF,
  localparam int IN_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // [SAMPLE_BITS-1:0] sample_low, [2*SAMPLE_BITS-1:SAMPLE_BITS] sample_high
  input  logic [IN_W-1:0]        s_axis_tdata_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [7:0] angle_deg, [15:8] report_angle
  output logic [15:0]            m_axis_tdata_o,
  // [1:0] range_used
  output logic [1:0]             m_axis_tuser_o,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_addr_i,
  input  logic [SAMPLE_BITS-1:0] cfg_wdata_i
);

  localparam int SB = SAMPLE_BITS;
  localparam int NW = SB + 14;
  localparam int DW = SB + 4;
  localparam int CW = SB + 12;
  // Scaled span width, reciprocal width and shift of the increment multiplication.
  localparam int MW = SB + 10;
  localparam int RW = SB + 11;
  localparam int INC_SHIFT = SB + 17;
  localparam longint INC_RECIP = ((longint'(1) << INC_SHIFT) +
                                  longint'(dpvae_pkg::DEG_SPAN) - 1) /
                                 longint'(dpvae_pkg::DEG_SPAN);

  // Calibration registers.
  logic [SB-1:0] zero_q, low90_q, high90_q, full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_q   <= SB'(dpvae_pkg::ZERO_RESET);
      low90_q  <= SB'(dpvae_pkg::LOW_NINETY_RESET);
      high90_q <= SB'(dpvae_pkg::HIGH_NINETY_RESET);
      full_q   <= SB'(dpvae_pkg::FULL_RESET);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        dpvae_pkg::REG_ZERO:        zero_q   <= cfg_wdata_i;
        dpvae_pkg::REG_LOW_NINETY:  low90_q  <= cfg_wdata_i;
        dpvae_pkg::REG_HIGH_NINETY: high90_q <= cfg_wdata_i;
        dpvae_pkg::REG_FULL:        full_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  dpvae_pkg::state_e state_q, state_d;
  dpvae_pkg::range_e range_q, range_d;
  logic              skip_q, skip_d;
  logic [7:0]        held_q, held_d;
  logic              mvalid_q, mvalid_d;

  logic [SB-1:0] sl_q, sl_d, sh_q, sh_d;
  logic [SB-1:0] diff_q, diff_d, delta_q, delta_d;
  logic [NW-1:0] num_q, num_d;
  logic [DW-1:0] inc_q, inc_d;
  logic [NW-1:0] tenths_q, tenths_d;
  logic [7:0]    angle_q, angle_d;
  logic [7:0]    out_angle_q, out_angle_d, out_report_q, out_report_d;
  logic [1:0]    out_range_q, out_range_d;

  logic                 div_start;
  logic [NW-1:0]        div_quot;
  dpvae_pkg::div_stat_t div_stat;

  logic [CW-1:0]    s0x, s1x, zx, l90x, h90x, fullx;
  logic             low_win, high_win;
  logic [SB-1:0]    sel_start, sel_end, sel_samp;
  logic [MW+RW-1:0] inc_prod;
  logic [18:0]      rnd_prod;
  logic [7:0]       rnd_deg;
  logic             at_cap;
  logic [15:0]      rep_prod;
  logic [4:0]       rep_tens;
  logic             out_free;

  // Window tests on widened values so the margins cannot wrap.
  assign s0x   = CW'(sl_q);
  assign s1x   = CW'(sh_q);
  assign zx    = CW'(zero_q);
  assign l90x  = CW'(low90_q);
  assign h90x  = CW'(high90_q);
  assign fullx = CW'(full_q);

  assign low_win  = (s0x <= l90x) && (s0x + CW'(dpvae_pkg::WIN_MARGIN) >= zx) &&
                    ((s1x > CW'(dpvae_pkg::LOW_HIGH_ABOVE)) ||
                     (s1x < CW'(dpvae_pkg::LOW_HIGH_BELOW)));
  assign high_win = (s1x >= h90x) && (s1x <= fullx + CW'(dpvae_pkg::WIN_MARGIN)) &&
                    ((s0x >= l90x) || (s0x <= CW'(dpvae_pkg::HIGH_LOW_GUARD)));

  // End points of the chosen range; the high range wins.
  assign sel_start = high_win ? high90_q : zero_q;
  assign sel_end   = high_win ? full_q   : low90_q;
  assign sel_samp  = high_win ? sh_q     : sl_q;

  // Increment: the scaled span over ninety by reciprocal multiplication, exact for
  // every span that the sample width allows.
  assign inc_prod = (MW+RW)'(num_q[MW-1:0]) * (MW+RW)'(INC_RECIP);

  // Rounding of tenths to whole degrees by reciprocal multiplication.
  assign rnd_prod = (19'(tenths_q[9:0]) + 19'(dpvae_pkg::ROUND_HALF)) *
                    19'(dpvae_pkg::RECIP_TEN);
  assign rnd_deg  = 8'(rnd_prod >> dpvae_pkg::RECIP_SHIFT);
  assign at_cap   = (tenths_q >= NW'(dpvae_pkg::TENTHS_CAP));

  // Angle rounded to tens: quotient by ten, then times ten by shifts.
  assign rep_prod = (16'(angle_q) + 16'(dpvae_pkg::ROUND_HALF)) *
                    16'(dpvae_pkg::RECIP_TEN);
  assign rep_tens = 5'(rep_prod >> dpvae_pkg::RECIP_SHIFT);

  assign out_free = !mvalid_q || m_axis_tready_i;

  // Divider for the tenths.
  assign div_start = (state_q == dpvae_pkg::ST_TEN_GO);

  dpvae_div #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num_q),
    .den_i  (inc_q),
    .quot_o (div_quot),
    .stat_o (div_stat)
  );

  // Sequencer next state and datapath loads.
  always_comb begin
    state_d      = state_q;
    range_d      = range_q;
    skip_d       = skip_q;
    held_d       = held_q;
    mvalid_d     = mvalid_q;
    sl_d         = sl_q;
    sh_d         = sh_q;
    diff_d       = diff_q;
    delta_d      = delta_q;
    num_d        = num_q;
    inc_d        = inc_q;
    tenths_d     = tenths_q;
    angle_d      = angle_q;
    out_angle_d  = out_angle_q;
    out_report_d = out_report_q;
    out_range_d  = out_range_q;
    if (mvalid_q && m_axis_tready_i) begin
      mvalid_d = 1'b0;
    end
    case (state_q)
      dpvae_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          sl_d    = s_axis_tdata_i[SB-1:0];
          sh_d    = s_axis_tdata_i[2*SB-1:SB];
          state_d = dpvae_pkg::ST_SELECT;
        end
      end
      dpvae_pkg::ST_SELECT: begin
        range_d = high_win ? dpvae_pkg::RANGE_HIGH :
                  (low_win ? dpvae_pkg::RANGE_LOW : dpvae_pkg::RANGE_HELD);
        skip_d  = (sel_end <= sel_start) || (sel_samp <= sel_start);
        diff_d  = sel_end - sel_start;
        delta_d = sel_samp - sel_start;
        state_d = (high_win || low_win) ? dpvae_pkg::ST_SCALE : dpvae_pkg::ST_ROUND;
      end
      dpvae_pkg::ST_SCALE: begin
        num_d   = NW'(diff_q) * NW'(dpvae_pkg::CAL_SCALE);
        state_d = skip_q ? dpvae_pkg::ST_ROUND : dpvae_pkg::ST_INC;
      end
      dpvae_pkg::ST_INC: begin
        inc_d   = inc_prod[INC_SHIFT +: DW];
        num_d   = NW'(delta_q) * NW'(dpvae_pkg::TENTHS_SCALE);
        state_d = dpvae_pkg::ST_TEN_GO;
      end
      dpvae_pkg::ST_TEN_GO: begin
        state_d = dpvae_pkg::ST_TEN_WAIT;
      end
      dpvae_pkg::ST_TEN_WAIT: begin
        if (div_stat.done) begin
          tenths_d = div_quot;
          state_d  = dpvae_pkg::ST_ROUND;
        end
      end
      dpvae_pkg::ST_ROUND: begin
        case (range_q)
          dpvae_pkg::RANGE_LOW: begin
            angle_d = skip_q ? 8'd0 :
                      (at_cap ? 8'(dpvae_pkg::LOW_CAP_DEG) : rnd_deg);
          end
          dpvae_pkg::RANGE_HIGH: begin
            angle_d = 8'(dpvae_pkg::HIGH_BASE) + (skip_q ? 8'd0 :
                      (at_cap ? 8'(dpvae_pkg::HIGH_CAP_DEG) : rnd_deg));
          end
          default: begin
            angle_d = held_q;
          end
        endcase
        state_d = dpvae_pkg::ST_EMIT;
      end
      dpvae_pkg::ST_EMIT: begin
        if (out_free) begin
          held_d       = angle_q;
          out_angle_d  = angle_q;
          out_report_d = {rep_tens[4:0], 3'b000} + {2'b00, rep_tens[4:0], 1'b0};
          out_range_d  = range_q;
          mvalid_d     = 1'b1;
          state_d      = dpvae_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dpvae_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dpvae_pkg::ST_IDLE;
      range_q  <= dpvae_pkg::RANGE_HELD;
      skip_q   <= 1'b0;
      held_q   <= '0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      range_q  <= range_d;
      skip_q   <= skip_d;
      held_q   <= held_d;
      mvalid_q <= mvalid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    sl_q         <= sl_d;
    sh_q         <= sh_d;
    diff_q       <= diff_d;
    delta_q      <= delta_d;
    num_q        <= num_d;
    inc_q        <= inc_d;
    tenths_q     <= tenths_d;
    angle_q      <= angle_d;
    out_angle_q  <= out_angle_d;
    out_report_q <= out_report_d;
    out_range_q  <= out_range_d;
  end

  assign s_axis_tready_o = (state_q == dpvae_pkg::ST_IDLE);
  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = {out_report_q, out_angle_q};
  assign m_axis_tuser_o  = out_range_q;

`ifndef SYNTH
  // The divider is never busy while a new request can be taken.
  a_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !div_stat.busy)
    else $error("divider busy while idle");

  // A divider result only arrives while the sequencer waits for it.
  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == dpvae_pkg::ST_TEN_WAIT))
    else $error("divider result outside a wait state");

  // A high range result never lies below ninety degrees.
  a_high_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == dpvae_pkg::RANGE_HIGH) |->
    (m_axis_tdata_o[7:0] >= 8'(dpvae_pkg::HIGH_BASE)))
    else $error("high range angle below ninety");

  // Results stay within the angle span.
  a_full_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[7:0] <= 8'(dpvae_pkg::FULL_SCALE_DEG)))
    else $error("angle beyond full scale");

  // A held result repeats the angle of the previous result.
  a_held_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dpvae_pkg::ST_EMIT && out_free && range_q == dpvae_pkg::RANGE_HELD) |=>
    (m_axis_tdata_o[7:0] == $past(held_q)))
    else $error("held angle changed");
`endif

endmodule
